>>> rtl/izc_pkg.sv
// ----------------------------------------------------------------------------
// Irrigation zone controller package
// Shared widths, codes and the result word type.
// ----------------------------------------------------------------------------
package izc_pkg;

    localparam int unsigned OP_W     = 3;
    localparam int unsigned HUM_W    = 12;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECS_W   = 16;
    localparam int unsigned DATE_W   = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned SCNT_W   = 4;
    localparam int unsigned CIDX_W   = 3;
    localparam int unsigned CDATA_W  = 16;

    localparam int unsigned SAMPLE_TICKS_DEF = 10;

    localparam logic [YEAR_W-1:0] BASE_YEAR = YEAR_W'(2000);

    localparam logic [OP_W-1:0] OP_TICK        = 3'd0;
    localparam logic [OP_W-1:0] OP_MAN_OPEN    = 3'd1;
    localparam logic [OP_W-1:0] OP_MAN_CLOSE   = 3'd2;
    localparam logic [OP_W-1:0] OP_MAN_ONLY    = 3'd3;
    localparam logic [OP_W-1:0] OP_PROGRAMMED  = 3'd4;
    localparam logic [OP_W-1:0] OP_AUTOMATIC   = 3'd5;

    localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PROG   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_WAIT  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_WATER = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_REST  = 2'd2;

    localparam logic [CIDX_W-1:0] REG_LOW_THRESHOLD  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_HIGH_THRESHOLD = 3'd1;
    localparam logic [CIDX_W-1:0] REG_WATER_SECONDS  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_REST_SECONDS   = 3'd3;
    localparam logic [CIDX_W-1:0] REG_START_DATE     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_START_HOUR     = 3'd5;
    localparam logic [CIDX_W-1:0] REG_START_MINUTE   = 3'd6;

    typedef struct packed {
        logic               valve_open;
        logic [MODE_W-1:0]  mode_now;
        logic [PHASE_W-1:0] phase_now;
    } result_t;

endpackage

>>> rtl/irrigation_zone_controller_top.sv
// ----------------------------------------------------------------------------
// Irrigation zone controller
// Valve control for one zone in manual, automatic and programmed modes.
// ----------------------------------------------------------------------------
// Each accepted word (a one-second tick or a command) yields one result word,
// holding the valve drive, the mode and the phase after the update. A new
// word can be taken in every cycle while in_stall is low: the whole update
// is one pass of compare and 16-bit countdown logic into the state and result
// registers. A two-entry output stage (result register plus skid register)
// keeps input stall registered; input stalls only while both entries are full.
// Configuration is written through a separate port that is always ready.
module irrigation_zone_controller_top #(
    parameter int unsigned SAMPLE_TICKS = izc_pkg::SAMPLE_TICKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [izc_pkg::OP_W-1:0]      op,
    input  logic [izc_pkg::HUM_W-1:0]     humidity,
    input  logic [izc_pkg::YEAR_W-1:0]    now_year,
    input  logic [izc_pkg::MONTH_W-1:0]   now_month,
    input  logic [izc_pkg::DAY_W-1:0]     now_day,
    input  logic [izc_pkg::HOUR_W-1:0]    now_hour,
    input  logic [izc_pkg::MINUTE_W-1:0]  now_minute,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          valve_open,
    output logic [izc_pkg::MODE_W-1:0]    mode_now,
    output logic [izc_pkg::PHASE_W-1:0]   phase_now,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [izc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [izc_pkg::CDATA_W-1:0]   cfg_data
);
    import izc_pkg::*;

    localparam logic [SCNT_W-1:0] SAMPLE_RELOAD = SCNT_W'(SAMPLE_TICKS);

    logic [HUM_W-1:0]    low_threshold_reg;
    logic [HUM_W-1:0]    high_threshold_reg;
    logic [SECS_W-1:0]   water_seconds_reg;
    logic [SECS_W-1:0]   rest_seconds_reg;
    logic [DATE_W-1:0]   start_date_reg;
    logic [HOUR_W-1:0]   start_hour_reg;
    logic [MINUTE_W-1:0] start_minute_reg;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [SECS_W-1:0]   pcnt_reg, pcnt_next;
    logic [SCNT_W-1:0]   scnt_reg, scnt_next;
    logic                sampling_reg, sampling_next;
    logic                valve_reg, valve_next;

    result_t             out_reg, skid_reg, result_next;
    logic                out_valid_reg, skid_valid_reg;

    logic                in_fire;
    logic                out_free;
    logic [YEAR_W-1:0]   start_year;
    logic                date_match;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign valve_open = out_reg.valve_open;
    assign mode_now   = out_reg.mode_now;
    assign phase_now  = out_reg.phase_now;

    assign start_year = BASE_YEAR + YEAR_W'(start_date_reg[DATE_W-1:9]);
    assign date_match = (now_year == start_year)
                     && (now_month == start_date_reg[8:5])
                     && (now_day == start_date_reg[4:0])
                     && (now_hour == start_hour_reg)
                     && (now_minute == start_minute_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_threshold_reg  <= '0;
            high_threshold_reg <= HUM_W'(4095);
            water_seconds_reg  <= SECS_W'(60);
            rest_seconds_reg   <= SECS_W'(3600);
            start_date_reg     <= '0;
            start_hour_reg     <= '0;
            start_minute_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LOW_THRESHOLD:  low_threshold_reg  <= cfg_data[HUM_W-1:0];
                REG_HIGH_THRESHOLD: high_threshold_reg <= cfg_data[HUM_W-1:0];
                REG_WATER_SECONDS:  water_seconds_reg  <= cfg_data[SECS_W-1:0];
                REG_REST_SECONDS:   rest_seconds_reg   <= cfg_data[SECS_W-1:0];
                REG_START_DATE:     start_date_reg     <= cfg_data[DATE_W-1:0];
                REG_START_HOUR:     start_hour_reg     <= cfg_data[HOUR_W-1:0];
                REG_START_MINUTE:   start_minute_reg   <= cfg_data[MINUTE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        logic fresh;
        logic fire;
        mode_next     = mode_reg;
        phase_next    = phase_reg;
        pcnt_next     = pcnt_reg;
        scnt_next     = scnt_reg;
        sampling_next = sampling_reg;
        valve_next    = valve_reg;
        fresh         = 1'b0;
        fire          = 1'b0;

        unique case (op)
            OP_MAN_OPEN, OP_MAN_CLOSE, OP_MAN_ONLY:
            begin
                mode_next     = MODE_MANUAL;
                sampling_next = 1'b0;
                if (op == OP_MAN_OPEN)
                    valve_next = 1'b1;
                if (op == OP_MAN_CLOSE)
                    valve_next = 1'b0;
            end
            OP_PROGRAMMED:
            begin
                mode_next     = MODE_PROG;
                sampling_next = 1'b0;
                phase_next    = PHASE_WAIT;
            end
            OP_AUTOMATIC:
            begin
                mode_next     = MODE_AUTO;
                sampling_next = 1'b1;
                scnt_next     = SAMPLE_RELOAD;
            end
            default:
            begin
                if (mode_reg == MODE_AUTO)
                begin
                    if (sampling_reg)
                    begin
                        if (scnt_reg <= SCNT_W'(1))
                        begin
                            scnt_next = SAMPLE_RELOAD;
                            if (humidity <= low_threshold_reg && phase_next == PHASE_WAIT)
                            begin
                                valve_next = 1'b1;
                                phase_next = PHASE_WATER;
                            end
                            if (humidity >= high_threshold_reg && phase_next == PHASE_WATER)
                            begin
                                valve_next = 1'b0;
                                phase_next = PHASE_WAIT;
                            end
                        end
                        else
                            scnt_next = scnt_reg - SCNT_W'(1);
                    end
                end
                else if (mode_reg == MODE_PROG)
                begin
                    if (phase_next == PHASE_WAIT && date_match)
                    begin
                        valve_next = 1'b1;
                        phase_next = PHASE_WATER;
                        pcnt_next  = water_seconds_reg;
                        fresh      = 1'b1;
                    end
                    if (phase_next == PHASE_WATER)
                    begin
                        if (fresh)
                            fire = (water_seconds_reg == '0);
                        else
                        begin
                            fire      = (pcnt_reg <= SECS_W'(1));
                            pcnt_next = fire ? water_seconds_reg : pcnt_reg - SECS_W'(1);
                        end
                        if (fire)
                        begin
                            valve_next = 1'b0;
                            phase_next = PHASE_REST;
                            pcnt_next  = rest_seconds_reg;
                            fresh      = 1'b1;
                        end
                    end
                    if (phase_next == PHASE_REST)
                    begin
                        if (fresh)
                            fire = (rest_seconds_reg == '0);
                        else
                        begin
                            fire      = (pcnt_reg <= SECS_W'(1));
                            pcnt_next = fire ? rest_seconds_reg : pcnt_reg - SECS_W'(1);
                        end
                        if (fire)
                        begin
                            valve_next = 1'b1;
                            phase_next = PHASE_WATER;
                            pcnt_next  = water_seconds_reg;
                        end
                    end
                end
            end
        endcase

        result_next.valve_open = valve_next;
        result_next.mode_now   = mode_next;
        result_next.phase_now  = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            phase_reg    <= PHASE_WAIT;
            pcnt_reg     <= '0;
            scnt_reg     <= '0;
            sampling_reg <= 1'b0;
            valve_reg    <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            pcnt_reg     <= pcnt_next;
            scnt_reg     <= scnt_next;
            sampling_reg <= sampling_next;
            valve_reg    <= valve_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_reg <= skid_valid_reg ? skid_reg : result_next;
        else if (in_fire)
            skid_reg <= result_next;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without a result word ahead of it");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no result word");

    a_sampling_auto_only: assert property (@(posedge clk) disable iff (!rst_n)
        sampling_reg |-> mode_reg == MODE_AUTO)
        else $error("humidity sampling running outside automatic mode");

    a_none_mode_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_NONE |-> !valve_reg && phase_reg == PHASE_WAIT)
        else $error("valve or phase moved before any mode was chosen");

endmodule
